FILE: design/dcc4_pkg.sv
// shared types and constants for the depthwise causal 4-tap convolution step
// no dependencies

package dcc4_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int CHANNEL_WIDTH = 8;
   localparam int ROW_WIDTH = 3 * SAMPLE_WIDTH;
   localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH;
   localparam int SUM_WIDTH = PROD_WIDTH + 4;
   localparam int FRAC_SHIFT = 14;
   localparam int ROUNDED_WIDTH = SUM_WIDTH - FRAC_SHIFT;

   localparam logic FUNC_FILTER = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(8192);
   localparam logic signed [ROUNDED_WIDTH-1:0] OUT_MAX = ROUNDED_WIDTH'(32767);
   localparam logic signed [ROUNDED_WIDTH-1:0] OUT_MIN = -ROUNDED_WIDTH'(32768);

   typedef struct packed {
      logic capture;
      logic mul;
      logic add;
      logic out_load;
      logic sweep;
   } cmd_type;

   typedef struct packed {
      logic ch_ok;
      logic out_free;
      logic sweep_last;
   } status_type;

endpackage

FILE: design/dcc4_if.sv
// request and response channel interfaces, valid/ready handshake
// depends on dcc4_pkg

interface dcc4_req_if;
   logic valid;
   logic ready;
   logic func;
   logic [dcc4_pkg::CHANNEL_WIDTH-1:0] channel;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] sample;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] weight_oldest;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] weight_older;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] weight_prev;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] weight_now;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] bias;

   modport source (
      output valid, func, channel, sample, weight_oldest, weight_older, weight_prev,
         weight_now, bias,
      input ready
   );
   modport sink (
      input valid, func, channel, sample, weight_oldest, weight_older, weight_prev,
         weight_now, bias,
      output ready
   );
endinterface

interface dcc4_rsp_if;
   logic valid;
   logic ready;
   logic [dcc4_pkg::CHANNEL_WIDTH-1:0] out_channel;
   logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0] out_value;
   logic saturated;

   modport source (output valid, out_channel, out_value, saturated, input ready);
   modport sink (input valid, out_channel, out_value, saturated, output ready);
endinterface

FILE: design/depthwise_causal_conv4_step.sv
// depthwise causal 4-tap convolution step, one channel sample per request
// an accepted filter request runs multiply, add and result load; the response goes valid in
//   the cycle that ready comes back; ready stays low until then, also while a held response
//   blocks the result step; a clear sweeps min(CHANNELS, 256) rows, one per cycle, ready low
// reset: synchronous, active high; the same sweep runs after reset before the first request
// out-of-range channels are accepted and give no response

module depthwise_causal_conv4_step #(
   parameter int CHANNELS = 256
) (
   input  logic              clock,
   input  logic              reset,
   dcc4_req_if.sink          req_ch,
   dcc4_rsp_if.source        rsp_ch
);

   // command and status between the controller and the datapath
   dcc4_pkg::cmd_type    cmd;
   dcc4_pkg::status_type status;

   // controller: sweeps the history on reset or clear, then runs
   // read, multiply, add and result load for each filter request
   dcc4_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_func(req_ch.func),
      .req_ready(req_ch.ready),
      .status(status),
      .cmd(cmd)
   );

   // datapath: one history row per channel holds the last three samples;
   // four parallel multipliers, one adder stage, round and clip into
   // the response register, which frees the controller for the next request
   dcc4_dpath #(
      .CHANNELS(CHANNELS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_channel(req_ch.channel),
      .req_sample(req_ch.sample),
      .req_weight_oldest(req_ch.weight_oldest),
      .req_weight_older(req_ch.weight_older),
      .req_weight_prev(req_ch.weight_prev),
      .req_weight_now(req_ch.weight_now),
      .req_bias(req_ch.bias),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_out_channel(rsp_ch.out_channel),
      .rsp_out_value(rsp_ch.out_value),
      .rsp_saturated(rsp_ch.saturated)
   );

endmodule

FILE: design/dcc4_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module dcc4_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/dcc4_ctrl.sv
// controller state machine: clearing sweep, accept, multiply, add, result load
// depends on dcc4_pkg

module dcc4_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_ready,
   input  dcc4_pkg::status_type  status,
   output dcc4_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               if (req_func == dcc4_pkg::FUNC_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (status.ch_ok) begin
                  cmd.capture = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/dcc4_dpath.sv
// datapath: history ram, tap multipliers, sum, rounding, saturation, result register
// depends on dcc4_pkg and dcc4_ram

module dcc4_dpath #(
   parameter int CHANNELS = 256
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  dcc4_pkg::cmd_type                         cmd,
   output dcc4_pkg::status_type                      status,
   input  logic [dcc4_pkg::CHANNEL_WIDTH-1:0]        req_channel,
   input  logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  req_sample,
   input  logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  req_weight_oldest,
   input  logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  req_weight_older,
   input  logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  req_weight_prev,
   input  logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  req_weight_now,
   input  logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  req_bias,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [dcc4_pkg::CHANNEL_WIDTH-1:0]        rsp_out_channel,
   output logic signed [dcc4_pkg::SAMPLE_WIDTH-1:0]  rsp_out_value,
   output logic                                      rsp_saturated
);

   localparam int SW = dcc4_pkg::SAMPLE_WIDTH;
   localparam int PW = dcc4_pkg::PROD_WIDTH;
   localparam int UW = dcc4_pkg::SUM_WIDTH;
   localparam int RW = dcc4_pkg::ROUNDED_WIDTH;
   localparam int CW = dcc4_pkg::CHANNEL_WIDTH;
   // only channels below 2^CW can ever be addressed
   localparam int DEPTH = (CHANNELS < (1 << CW)) ? CHANNELS : (1 << CW);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CW-1:0]         ch_ff;
   logic signed [SW-1:0]  sample_ff;
   logic signed [SW-1:0]  w3_ff, w2_ff, w1_ff, w0_ff;
   logic signed [SW-1:0]  bias_ff;
   logic [AW-1:0]         sweep_ff;
   logic [AW-1:0]         sweep_in;
   logic signed [PW-1:0]  p3_ff, p2_ff, p1_ff, p0_ff;
   logic signed [PW-1:0]  bias_sh_ff;
   logic signed [UW-1:0]  sum_ff;
   logic                  out_valid_ff;
   logic [CW-1:0]         out_channel_ff;
   logic signed [SW-1:0]  out_value_ff;
   logic                  out_sat_ff;

   logic [dcc4_pkg::ROW_WIDTH-1:0] rd_row;
   logic [dcc4_pkg::ROW_WIDTH-1:0] wr_row;
   logic [AW-1:0]                  wr_addr;
   logic                           wr_en;
   logic signed [SW-1:0]           back1, back2, back3;
   logic signed [UW-1:0]           sum_in;
   logic signed [UW-1:0]           biased;
   logic signed [RW-1:0]           rounded;
   logic signed [SW-1:0]           value_in;
   logic                           sat_in;

   assign status.ch_ok = (32'(req_channel) < CHANNELS);
   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.sweep_last = (sweep_ff == AW'(DEPTH - 1));

   // row layout: oldest sample on top, newest past sample at the bottom
   assign back3 = rd_row[3*SW-1:2*SW];
   assign back2 = rd_row[2*SW-1:SW];
   assign back1 = rd_row[SW-1:0];

   assign wr_en = cmd.mul || cmd.sweep;
   assign wr_addr = cmd.sweep ? sweep_ff : ch_ff[AW-1:0];
   assign wr_row = cmd.sweep ? '0 : {back2, back1, sample_ff};

   dcc4_ram #(
      .WIDTH(dcc4_pkg::ROW_WIDTH),
      .DEPTH(DEPTH),
      .ADDR_WIDTH(AW)
   ) u_hist (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_en(cmd.capture),
      .rd_addr(req_channel[AW-1:0]),
      .rd_data(rd_row)
   );

   assign sweep_in = status.sweep_last ? '0 : sweep_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff <= req_channel;
         sample_ff <= req_sample;
         w3_ff <= req_weight_oldest;
         w2_ff <= req_weight_older;
         w1_ff <= req_weight_prev;
         w0_ff <= req_weight_now;
         bias_ff <= req_bias;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p3_ff <= PW'(back3 * w3_ff);
         p2_ff <= PW'(back2 * w2_ff);
         p1_ff <= PW'(back1 * w1_ff);
         p0_ff <= PW'(sample_ff * w0_ff);
         bias_sh_ff <= PW'(bias_ff) <<< dcc4_pkg::FRAC_SHIFT;
      end
   end

   assign sum_in = UW'(p3_ff) + UW'(p2_ff) + UW'(p1_ff) + UW'(p0_ff) + UW'(bias_sh_ff);

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         sum_ff <= sum_in;
      end
   end

   // round half up, then clip to the 16-bit range
   assign biased = sum_ff + dcc4_pkg::ROUND_HALF;
   assign rounded = RW'(biased >>> dcc4_pkg::FRAC_SHIFT);

   always_comb begin
      if (rounded > dcc4_pkg::OUT_MAX) begin
         value_in = SW'(dcc4_pkg::OUT_MAX);
         sat_in = 1'b1;
      end else if (rounded < dcc4_pkg::OUT_MIN) begin
         value_in = SW'(dcc4_pkg::OUT_MIN);
         sat_in = 1'b1;
      end else begin
         value_in = SW'(rounded);
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_channel_ff <= ch_ff;
         out_value_ff <= value_in;
         out_sat_ff <= sat_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_channel = out_channel_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_saturated = out_sat_ff;

endmodule
